/* rtl/eabb_pkg.sv */
package eabb_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int LINE_SLOTS_DEF = 3;

   // Field and register widths.
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 3 * CHAN_W;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 16;

   // Window sums: nine 8-bit values fit in 12 bits.
   localparam int SUM_W = 12;
   localparam int CNT_W = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   // Reciprocals for division by 3 and by 9, exact for numerators below 4096.
   localparam int RECIP3 = 2731;
   localparam int SHIFT3 = 13;
   localparam int RECIP9 = 3641;
   localparam int SHIFT9 = 15;

   // Rounded mean of a window sum, half up: floor((sum + floor(cnt/2)) / cnt).
   // A count of six divides by two first and then by three.
   function automatic logic [CHAN_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                     input logic [CNT_W-1:0] cnt);
      logic [SUM_W-1:0]   num;
      logic [SUM_W-1:0]   mop;
      logic [2*SUM_W-1:0] p3;
      logic [2*SUM_W-1:0] p9;
      logic [SUM_W-1:0]   q;
      num = sum + SUM_W'(cnt >> 1);
      mop = (cnt == CNT_W'(6)) ? (num >> 1) : num;
      p3  = (2*SUM_W)'(mop) * (2*SUM_W)'(RECIP3);
      p9  = (2*SUM_W)'(num) * (2*SUM_W)'(RECIP9);
      unique case (cnt)
         CNT_W'(2): q = num >> 1;
         CNT_W'(3),
         CNT_W'(6): q = SUM_W'(p3 >> SHIFT3);
         CNT_W'(4): q = num >> 2;
         CNT_W'(9): q = SUM_W'(p9 >> SHIFT9);
         default:   q = num;
      endcase
      return q[CHAN_W-1:0];
   endfunction

endpackage

/* rtl/edge_aware_box_blur_3x3_top.sv */
// Each item is accepted, checked and, when it releases a result, its window is read
// row by row from the line memory, one window pixel per cycle, before the mean is
// formed and the pixel written back; the result word is registered. A new item is
// taken only once the block is through with the last one.
// Reset clears all counters and control state and sets both frame registers to 1;
// the line memory is not cleared and needs no clearing pass.
module edge_aware_box_blur_3x3_top
   import eabb_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int LINE_SLOTS = LINE_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input pixel stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic                  req_tuser,   // op: 0 pixel, 1 drain tick
   // Blurred pixel stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic                  rsp_tlast,   // frame_end
   // Register writes.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WID_W     = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W     = (WID_W > WIDTH_REG_W) ? WID_W : WIDTH_REG_W;
   localparam int SLOT_W    = $clog2(LINE_SLOTS);
   localparam int ADDR_W    = SLOT_W + COL_W;
   localparam int MEM_DEPTH = LINE_SLOTS * (2 ** COL_W);
   localparam int ROW_W     = HEIGHT_REG_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHK  = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(LINE_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
      return (s == '0) ? SLOT_W'(LINE_SLOTS - 1) : s - SLOT_W'(1);
   endfunction

   logic [2:0]             state_ff, state_in;
   logic [WIDTH_REG_W-1:0] width_reg_ff, width_reg_in;
   logic [ROW_W-1:0]       height_reg_ff, height_reg_in;
   logic [ROW_W-1:0]       in_row_ff, in_row_in;
   logic [COL_W-1:0]       in_col_ff, in_col_in;
   logic [SLOT_W-1:0]      in_slot_ff, in_slot_in;
   logic [ROW_W-1:0]       out_row_ff, out_row_in;
   logic [COL_W-1:0]       out_col_ff, out_col_in;
   logic [SLOT_W-1:0]      out_slot_ff, out_slot_in;
   logic                   frame_full_ff, frame_full_in;
   logic [PIX_W-1:0]       item_pix_ff, item_pix_in;
   logic                   item_acc_ff, item_acc_in;
   logic                   item_due_ff, item_due_in;
   logic [ROW_W-1:0]       win_ny_ff, win_ny_in;
   logic [COL_W-1:0]       win_x0_ff, win_x0_in;
   logic [COL_W-1:0]       win_nx_ff, win_nx_in;
   logic [ROW_W-1:0]       rd_row_ff, rd_row_in;
   logic [COL_W-1:0]       rd_col_ff, rd_col_in;
   logic [SLOT_W-1:0]      rd_slot_ff, rd_slot_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   fwd_ff, fwd_in;
   logic [SUM_W-1:0]       sum_r_ff, sum_r_in;
   logic [SUM_W-1:0]       sum_g_ff, sum_g_in;
   logic [SUM_W-1:0]       sum_b_ff, sum_b_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [PIX_W-1:0]       line_mem [0:MEM_DEPTH-1];
   logic [PIX_W-1:0]       rd_data_ff;

   logic [WID_W-1:0]       eff_w;
   logic [ROW_W-1:0]       eff_h;
   logic [ROW_W:0]         out_row_p1;
   logic [ROW_W:0]         in_row_p1;
   logic [WID_W-1:0]       out_col_p1;
   logic [WID_W-1:0]       in_col_p1;
   logic [ROW_W-1:0]       ny;
   logic [COL_W-1:0]       nx;
   logic                   win_lt;
   logic                   win_eq;
   logic                   rd_en;
   logic                   wr_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;
   logic [PIX_W-1:0]       acc_pix;
   logic                   fin_go;

   // Effective frame size: zero counts as one, width is clamped to the line length.
   always_comb begin
      if (width_reg_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (CMP_W'(width_reg_ff) > CMP_W'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_reg_ff);
      end
      eff_h = (height_reg_ff == '0) ? ROW_W'(1) : height_reg_ff;
   end

   // Position of the last neighbour of the next output pixel.
   assign out_row_p1 = {1'b0, out_row_ff} + (ROW_W+1)'(1);
   assign in_row_p1  = {1'b0, in_row_ff} + (ROW_W+1)'(1);
   assign out_col_p1 = WID_W'(out_col_ff) + WID_W'(1);
   assign in_col_p1  = WID_W'(in_col_ff) + WID_W'(1);
   assign ny = (out_row_p1 < {1'b0, eff_h}) ? out_row_p1[ROW_W-1:0] : eff_h - ROW_W'(1);
   assign nx = (out_col_p1 < eff_w) ? COL_W'(out_col_p1) : COL_W'(eff_w - WID_W'(1));

   // Raster order compare of that neighbour against the next input position.
   assign win_lt = (ny < in_row_ff) || ((ny == in_row_ff) && (nx < in_col_ff));
   assign win_eq = (ny == in_row_ff) && (nx == in_col_ff);

   // Window pixel being summed: the arriving pixel is forwarded over the memory word.
   assign acc_pix = fwd_ff ? item_pix_ff : rd_data_ff;

   assign fin_go = !item_due_ff || !rsp_valid_ff || rsp_tready;

   // Memory access control.
   assign rd_en   = (state_ff == ST_READ);
   assign rd_addr = {rd_slot_ff, rd_col_ff};
   assign wr_en   = (state_ff == ST_FIN) && fin_go && item_acc_ff;
   assign wr_addr = {in_slot_ff, in_col_ff};

   // Handshakes.
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Sequencer: accept, check, read the window, sum, then divide and write back.
   always_comb begin
      state_in      = state_ff;
      width_reg_in  = width_reg_ff;
      height_reg_in = height_reg_ff;
      in_row_in     = in_row_ff;
      in_col_in     = in_col_ff;
      in_slot_in    = in_slot_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_slot_in   = out_slot_ff;
      frame_full_in = frame_full_ff;
      item_pix_in   = item_pix_ff;
      item_acc_in   = item_acc_ff;
      item_due_in   = item_due_ff;
      win_ny_in     = win_ny_ff;
      win_x0_in     = win_x0_ff;
      win_nx_in     = win_nx_ff;
      rd_row_in     = rd_row_ff;
      rd_col_in     = rd_col_ff;
      rd_slot_in    = rd_slot_ff;
      rd_vld_in     = (state_ff == ST_READ);
      fwd_in        = item_acc_ff && (rd_row_ff == in_row_ff) && (rd_col_ff == in_col_ff);
      sum_r_in      = sum_r_ff;
      sum_g_in      = sum_g_ff;
      sum_b_in      = sum_b_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      // Accumulate the word read in the previous cycle.
      if (rd_vld_ff) begin
         sum_r_in = sum_r_ff + SUM_W'(acc_pix[CHAN_W-1:0]);
         sum_g_in = sum_g_ff + SUM_W'(acc_pix[2*CHAN_W-1:CHAN_W]);
         sum_b_in = sum_b_ff + SUM_W'(acc_pix[3*CHAN_W-1:2*CHAN_W]);
         cnt_in   = cnt_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               // A write to the width or height register restarts the frame; the line memory is kept.
               if (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT) begin
                  if (csr_index == CSR_FRAME_WIDTH) begin
                     width_reg_in = csr_data[WIDTH_REG_W-1:0];
                  end else begin
                     height_reg_in = csr_data[HEIGHT_REG_W-1:0];
                  end
                  in_row_in     = '0;
                  in_col_in     = '0;
                  in_slot_in    = '0;
                  out_row_in    = '0;
                  out_col_in    = '0;
                  out_slot_in   = '0;
                  frame_full_in = 1'b0;
               end
            end else if (req_tvalid) begin
               item_pix_in = req_tdata;
               item_acc_in = !req_tuser && !frame_full_ff;
               state_in    = ST_CHK;
            end
         end
         ST_CHK: begin
            // Decide whether the next output is due and set up the window scan.
            item_due_in = (out_row_ff < eff_h) &&
                          (frame_full_ff || win_lt || (item_acc_ff && win_eq));
            win_ny_in  = ny;
            win_nx_in  = nx;
            win_x0_in  = (out_col_ff == '0) ? '0 : out_col_ff - COL_W'(1);
            rd_col_in  = (out_col_ff == '0) ? '0 : out_col_ff - COL_W'(1);
            rd_row_in  = (out_row_ff == '0) ? '0 : out_row_ff - ROW_W'(1);
            rd_slot_in = (out_row_ff == '0) ? out_slot_ff : slot_prev(out_slot_ff);
            sum_r_in   = '0;
            sum_g_in   = '0;
            sum_b_in   = '0;
            cnt_in     = '0;
            state_in   = item_due_in ? ST_READ : ST_FIN;
         end
         ST_READ: begin
            // One window word per cycle, row by row.
            if (rd_col_ff == win_nx_ff) begin
               if (rd_row_ff == win_ny_ff) begin
                  state_in = ST_WAIT;
               end else begin
                  rd_col_in  = win_x0_ff;
                  rd_row_in  = rd_row_ff + ROW_W'(1);
                  rd_slot_in = slot_next(rd_slot_ff);
               end
            end else begin
               rd_col_in = rd_col_ff + COL_W'(1);
            end
         end
         ST_WAIT: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_go) begin
               if (item_due_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {round_mean(sum_b_ff, cnt_ff),
                                  round_mean(sum_g_ff, cnt_ff),
                                  round_mean(sum_r_ff, cnt_ff)};
                  rsp_last_in  = (out_row_ff == eff_h - ROW_W'(1)) &&
                                 (WID_W'(out_col_ff) == eff_w - WID_W'(1));
                  if (out_col_p1 < eff_w) begin
                     out_col_in = COL_W'(out_col_p1);
                  end else begin
                     out_col_in  = '0;
                     out_row_in  = out_row_ff + ROW_W'(1);
                     out_slot_in = slot_next(out_slot_ff);
                  end
               end
               if (item_acc_ff) begin
                  if (in_col_p1 < eff_w) begin
                     in_col_in = COL_W'(in_col_p1);
                  end else if (in_row_p1 < {1'b0, eff_h}) begin
                     in_col_in  = '0;
                     in_row_in  = in_row_p1[ROW_W-1:0];
                     in_slot_in = slot_next(in_slot_ff);
                  end else begin
                     frame_full_in = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_reg_ff  <= WIDTH_REG_W'(1);
         height_reg_ff <= ROW_W'(1);
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         in_slot_ff    <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         out_slot_ff   <= '0;
         frame_full_ff <= 1'b0;
         item_acc_ff   <= 1'b0;
         item_due_ff   <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         in_row_ff     <= in_row_in;
         in_col_ff     <= in_col_in;
         in_slot_ff    <= in_slot_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         out_slot_ff   <= out_slot_in;
         frame_full_ff <= frame_full_in;
         item_acc_ff   <= item_acc_in;
         item_due_ff   <= item_due_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_pix_ff <= item_pix_in;
      win_ny_ff   <= win_ny_in;
      win_x0_ff   <= win_x0_in;
      win_nx_ff   <= win_nx_in;
      rd_row_ff   <= rd_row_in;
      rd_col_ff   <= rd_col_in;
      rd_slot_ff  <= rd_slot_in;
      fwd_ff      <= fwd_in;
      sum_r_ff    <= sum_r_in;
      sum_g_ff    <= sum_g_in;
      sum_b_ff    <= sum_b_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Ring line memory: one slot per row, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= item_pix_ff;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;
   import eabb_pkg::*;

   localparam int MAXW          = MAX_WIDTH_DEF;
   localparam int SLOTS         = LINE_SLOTS_DEF;
   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_HOLD     = 600;
   localparam int PHASE_PIXELS  = 60;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOP = '1;

   typedef enum logic {OP_PIXEL = 1'b0, OP_DRAIN = 1'b1} blur_op_type;

   // One input word: red in the lowest byte, as on req_tdata.
   typedef struct packed {
      blur_op_type        op;
      logic [PIX_W-1:0]   pix;
   } blur_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } blurred_px_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   blur_word_type  pixel_feed[$];
   blurred_px_type due_pixels[$];

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   n_errors      = 0;
   logic pressure_arm  = 1'b0;
   int   hold_left;
   logic hold_used;

   // Shadow of the block's frame registers, counters and line store.
   logic [WIDTH_REG_W-1:0]  cfg_width;
   logic [HEIGHT_REG_W-1:0] cfg_height;
   int unsigned             in_row, in_col, out_row, out_col;
   bit                      frm_done;
   logic [PIX_W-1:0]        line_mem [SLOTS*MAXW];

   edge_aware_box_blur_3x3_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // A register write starts the frame again; the line store is kept.
   function automatic void restart_frame();
      in_row   = 0;
      in_col   = 0;
      out_row  = 0;
      out_col  = 0;
      frm_done = 1'b0;
   endfunction

   // Works out the blurred pixel, if any, that an accepted word releases,
   // then writes the arriving pixel into the line store.
   function automatic void blur_accept_word(input logic op, input logic [PIX_W-1:0] pix);
      int unsigned     w, h, ny, nx, y0, x0, y, x, cnt;
      int unsigned     s_r, s_g, s_b;
      longint unsigned arrived;
      bit              take;
      logic [PIX_W-1:0] p;
      blurred_px_type  res;
      w = (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      take = (op == OP_PIXEL) && !frm_done;
      arrived = frm_done ? longint'(w) * h : longint'(in_row) * w + in_col;
      if (take) arrived++;
      if (out_row < h) begin
         ny = (out_row + 1 < h) ? out_row + 1 : h - 1;
         nx = (out_col + 1 < w) ? out_col + 1 : w - 1;
         if (longint'(ny) * w + nx < arrived) begin
            s_r = 0;
            s_g = 0;
            s_b = 0;
            cnt = 0;
            y0 = (out_row > 0) ? out_row - 1 : 0;
            x0 = (out_col > 0) ? out_col - 1 : 0;
            for (y = y0; y <= ny; y++) begin
               for (x = x0; x <= nx; x++) begin
                  // The pixel arriving now is not yet in the store.
                  if (take && y == in_row && x == in_col)
                     p = pix;
                  else
                     p = line_mem[(y % SLOTS) * MAXW + (x % MAXW)];
                  s_r += p[CHAN_W-1:0];
                  s_g += p[2*CHAN_W-1:CHAN_W];
                  s_b += p[PIX_W-1:2*CHAN_W];
                  cnt++;
               end
            end
            // Mean rounded half up.
            res.red   = CHAN_W'((2 * s_r + cnt) / (2 * cnt));
            res.green = CHAN_W'((2 * s_g + cnt) / (2 * cnt));
            res.blue  = CHAN_W'((2 * s_b + cnt) / (2 * cnt));
            res.last  = (out_row == h - 1) && (out_col == w - 1);
            due_pixels.push_back(res);
            if (out_col + 1 < w) begin
               out_col++;
            end else begin
               out_col = 0;
               out_row++;
            end
         end
      end
      if (take) begin
         line_mem[(in_row % SLOTS) * MAXW + (in_col % MAXW)] = pix;
         if (in_col + 1 < w) begin
            in_col++;
         end else if (in_row + 1 < h) begin
            in_col = 0;
            in_row++;
         end else begin
            frm_done = 1'b1;
         end
      end
   endfunction

   // Driver: offers the next pending word whenever the previous one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pixel_feed[0].op;
            req_tdata  <= pixel_feed[0].pix;
            void'(pixel_feed.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off when armed.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_used  <= 1'b0;
      end else if (pressure_arm && !hold_used) begin
         hold_used  <= 1'b1;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: tracks register writes, predicts on accepted input words and
   // checks each accepted output word against the oldest expectation.
   always @(posedge clock) begin
      blurred_px_type want;
      if (reset) begin
         cfg_width  = WIDTH_REG_W'(1);
         cfg_height = HEIGHT_REG_W'(1);
         restart_frame();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FRAME_WIDTH) begin
               cfg_width = csr_data[WIDTH_REG_W-1:0];
               restart_frame();
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               cfg_height = csr_data[HEIGHT_REG_W-1:0];
               restart_frame();
            end
         end
         if (req_tvalid && req_tready)
            blur_accept_word(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (due_pixels.size() == 0) begin
               $error("unexpected blurred pixel: data %h, frame_end %b", rsp_tdata, rsp_tlast);
               n_errors++;
            end else begin
               want = due_pixels.pop_front();
               if (rsp_tdata[CHAN_W-1:0] !== want.red) begin
                  $error("red_out: expected %0d, got %0d", want.red, rsp_tdata[CHAN_W-1:0]);
                  n_errors++;
               end
               if (rsp_tdata[2*CHAN_W-1:CHAN_W] !== want.green) begin
                  $error("green_out: expected %0d, got %0d", want.green,
                         rsp_tdata[2*CHAN_W-1:CHAN_W]);
                  n_errors++;
               end
               if (rsp_tdata[PIX_W-1:2*CHAN_W] !== want.blue) begin
                  $error("blue_out: expected %0d, got %0d", want.blue,
                         rsp_tdata[PIX_W-1:2*CHAN_W]);
                  n_errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("frame_end: expected %0d, got %0d", want.last, rsp_tlast);
                  n_errors++;
               end
            end
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every word has been taken and every blurred pixel has come,
   // then lets the block finish any word that releases nothing.
   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_feed.size() != 0 || req_tvalid || due_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_word(input blur_op_type op, input logic [CHAN_W-1:0] r,
                            input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
      blur_word_type wd;
      wd.op  = op;
      wd.pix = {b, g, r};
      pixel_feed.push_back(wd);
   endtask

   task automatic push_drains(input int n);
      for (int i = 0; i < n; i++)
         push_word(OP_DRAIN, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
   endtask

   // A channel value that is often at one of its extremes.
   function automatic logic [CHAN_W-1:0] rand_chan();
      if ($urandom_range(5) == 0)
         return $urandom_range(1) ? '1 : '0;
      return CHAN_W'($urandom);
   endfunction

   // Queues n pixels with the odd drain tick mixed in.
   task automatic queue_pixels(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            push_drains(1);
         push_word(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      end
   endtask

   // Stimulus.
   initial begin
      int                    phase, done_px, npix, sel;
      int                    w_eff, h_eff, cur_w, cur_h;
      bit                    first;
      logic [CSR_DATA_W-1:0] wdata, hdata;
      logic [CHAN_W-1:0]     cr;

      @(negedge clock);
      while (reset) @(negedge clock);

      // Default one-pixel frame: idle drain, a pixel, one past the end, drain.
      push_word(OP_DRAIN, '1, '0, '1);
      push_word(OP_PIXEL, '1, '1, '1);
      push_word(OP_PIXEL, '0, '0, '0);
      push_drains(1);
      wait_idle();

      // Zero width and height both act as one; upper width bits are dropped.
      write_reg(CSR_FRAME_WIDTH, 16'hF800);
      write_reg(CSR_FRAME_HEIGHT, '0);
      push_word(OP_PIXEL, 8'h00, 8'hFF, 8'h81);
      wait_idle();

      // A write to an unknown index leaves the finished frame alone.
      write_reg(CSR_IDX_TOP, 16'h0005);
      push_word(OP_PIXEL, '1, '1, '1);
      push_drains(1);
      wait_idle();

      // Three by three frame: corners, edges and the centre, with a drain
      // tick part way through.
      write_reg(CSR_FRAME_WIDTH, 16'd3);
      write_reg(CSR_FRAME_HEIGHT, 16'd3);
      for (int k = 0; k < 9; k++) begin
         cr = k[0] ? '1 : '0;
         push_word(OP_PIXEL, cr, ~cr, CHAN_W'(k * 29));
         if (k == 4)
            push_drains(1);
      end
      push_drains(6);
      wait_idle();

      // Width beyond the line store, clamped to its full size, in one row.
      write_reg(CSR_FRAME_WIDTH, 16'h07FF);
      write_reg(CSR_FRAME_HEIGHT, 16'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_pixels(MAXW);
      push_drains(4);
      wait_idle();

      // Tallest frame, one pixel wide, only started.
      write_reg(CSR_FRAME_WIDTH, 16'd1);
      write_reg(CSR_FRAME_HEIGHT, 16'hFFFF);
      queue_pixels(12);
      push_drains(3);
      wait_idle();

      // Random frames, mostly complete, over three idling regimes.
      first = 1'b1;
      cur_w = 1;
      cur_h = 1;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         done_px = 0;
         while (done_px < PHASE_PIXELS) begin
            if (phase == 2 && done_px == 0) begin
               w_eff = 16;
               h_eff = 8;
            end else if ($urandom_range(7) == 0) begin
               w_eff = $urandom_range(9, 64);
               h_eff = $urandom_range(1, 3);
            end else begin
               w_eff = $urandom_range(1, 8);
               h_eff = $urandom_range(1, 7);
            end
            wdata = CSR_DATA_W'($urandom);
            wdata[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w_eff);
            if (w_eff == 1 && $urandom_range(1) == 0)
               wdata[WIDTH_REG_W-1:0] = '0;
            hdata = CSR_DATA_W'(h_eff);
            if (h_eff == 1 && $urandom_range(1) == 0)
               hdata = '0;
            if ($urandom_range(5) == 0)
               write_reg(CSR_IDX_W'($urandom_range(CSR_FRAME_HEIGHT + 1, CSR_IDX_TOP)),
                         CSR_DATA_W'($urandom));
            sel = (first || (phase == 2 && done_px == 0)) ? 0 : $urandom_range(5);
            if (sel == 3) begin
               h_eff = cur_h;
               write_reg(CSR_FRAME_WIDTH, wdata);
            end else if (sel == 4) begin
               w_eff = cur_w;
               write_reg(CSR_FRAME_HEIGHT, hdata);
            end else if (sel[0]) begin
               write_reg(CSR_FRAME_WIDTH, wdata);
               write_reg(CSR_FRAME_HEIGHT, hdata);
            end else begin
               write_reg(CSR_FRAME_HEIGHT, hdata);
               write_reg(CSR_FRAME_WIDTH, wdata);
            end
            cur_w = w_eff;
            cur_h = h_eff;
            first = 1'b0;

            // Now and then a frame is cut short; whole frames may get
            // pixels past their end, which the block must ignore.
            npix = w_eff * h_eff;
            if ($urandom_range(9) == 0)
               npix = $urandom_range(0, npix - 1);
            queue_pixels(npix);
            if (npix == w_eff * h_eff && $urandom_range(3) == 0)
               queue_pixels($urandom_range(1, 3));
            push_drains(w_eff + 3);
            if (phase == 2 && done_px == 0)
               pressure_arm <= 1'b1;
            done_px += npix;
            wait_idle();
         end
      end

      if (n_errors == 0) begin
         $display("** edge_aware_box_blur_3x3_top: PASSED **");
      end else begin
         $display("** edge_aware_box_blur_3x3_top: FAILED **");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20_000_000;
      $display("** edge_aware_box_blur_3x3_top: FAILED **");
      $finish;
   end

endmodule
